// ===== rtl/assert_macros.svh =====
// Assertion macros for the joystick report scheduler, used by jrs_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JRS_ASSERT_SEQ(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sequential check failed");
`define JRS_ASSERT_COMB(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("combinational check failed");
`else
`define JRS_ASSERT_SEQ(label, clk, rst_n, prop)
`define JRS_ASSERT_COMB(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/jrs_pkg.sv =====
// Types and constants of the joystick report scheduler.
package jrs_pkg;

  localparam int unsigned AXIS_W       = 16;
  localparam int unsigned MAX_AXES     = 4;
  localparam int unsigned AXES_DEFAULT = 4;
  localparam int unsigned IN_TDATA_W   = 184;
  localparam int unsigned OUT_TDATA_W  = 112;
  localparam logic [15:0] RESET_PERIOD_MS = 16'd500;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_SET     = 3'd1,
    ACT_ENABLE  = 3'd2,
    ACT_DISABLE = 3'd3,
    ACT_RESET   = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]                   action;
    logic [3:0]                   axis_en;
    logic [MAX_AXES*AXIS_W-1:0]   axes_packed;
    logic [31:0]                  button_mask;
    logic [31:0]                  button_values;
    logic [15:0]                  period_request_ms;
    logic                         host_mounted;
    logic                         send_ready;
    logic [31:0]                  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                         submit_strobe;
    logic                         report_sent;
    logic [MAX_AXES*AXIS_W-1:0]   axes_out;
    logic [31:0]                  buttons_out;
    logic                         report_mounted;
    logic [7:0]                   report_seq;
  } out_item_t;

endpackage

// ===== rtl/joystick_report_scheduler.sv =====
// Joystick report scheduler top level: request stream in, report stream out.
// Requests pass from the input register through the core logic to the output register.
// Throughput: one request per cycle while the report stream takes results, set by the state update loop in jrs_core.
// Reset: asynchronous active low; clears valid flags and core state at once, period and default back to 500.
module joystick_report_scheduler #(
  parameter int unsigned AXES = jrs_pkg::AXES_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // axis_en, axes_packed, button_mask, button_values, period_request_ms,
  // host_mounted, send_ready, now_ms, zero pad
  input  logic [jrs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // action
  input  logic [2:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // submit_strobe, report_sent, axes_out, buttons_out, report_mounted,
  // report_seq, zero pad
  output logic [jrs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  jrs_pkg::in_item_t  in_item, core_item;
  jrs_pkg::out_item_t core_result, out_item;
  logic               step;
  logic               out_ready;

  assign cfg_ready_o = 1'b1;

  assign in_item.action            = s_axis_tuser;
  assign in_item.axis_en           = s_axis_tdata[3:0];
  assign in_item.axes_packed       = s_axis_tdata[67:4];
  assign in_item.button_mask       = s_axis_tdata[99:68];
  assign in_item.button_values     = s_axis_tdata[131:100];
  assign in_item.period_request_ms = s_axis_tdata[147:132];
  assign in_item.host_mounted      = s_axis_tdata[148];
  assign in_item.send_ready        = s_axis_tdata[149];
  assign in_item.now_ms            = s_axis_tdata[181:150];

  jrs_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .item_i       (in_item),
    .down_ready_i (out_ready),
    .step_o       (step),
    .item_o       (core_item)
  );

  jrs_core #(
    .AXES (AXES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (core_item),
    .result_o   (core_result)
  );

  jrs_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .item_i       (core_result),
    .ready_o      (out_ready),
    .valid_o      (m_axis_tvalid),
    .down_ready_i (m_axis_tready),
    .item_o       (out_item)
  );

  assign m_axis_tdata = {5'd0,
                         out_item.report_seq,
                         out_item.report_mounted,
                         out_item.buttons_out,
                         out_item.axes_out,
                         out_item.report_sent,
                         out_item.submit_strobe};

endmodule

// ===== rtl/jrs_in_stage.sv =====
// Input register stage holding one accepted request.
module jrs_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  jrs_pkg::in_item_t item_i,
  input  logic              down_ready_i,
  output logic              step_o,
  output jrs_pkg::in_item_t item_o
);

  logic              valid_q;
  jrs_pkg::in_item_t item_q;

  assign step_o  = valid_q & down_ready_i;
  assign ready_o = ~valid_q | step_o;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/jrs_core.sv =====
// Scheduler state and the next-state logic for one request.
`include "assert_macros.svh"

module jrs_core #(
  parameter int unsigned AXES = jrs_pkg::AXES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               step_i,
  input  jrs_pkg::in_item_t  item_i,
  output jrs_pkg::out_item_t result_o
);

  localparam int unsigned AW = jrs_pkg::AXIS_W;

  logic [15:0]   default_period_q;
  logic          enabled_q, enabled_d;
  logic [AW-1:0] axis_q [AXES];
  logic [AW-1:0] axis_d [AXES];
  logic [31:0]   buttons_q, buttons_d;
  logic          mounted_prev_q, mounted_prev_d;
  logic [7:0]    seq_q, seq_d;
  logic          pending_q, pending_d;
  logic [31:0]   last_time_q, last_time_d;
  logic [15:0]   period_q, period_d;

  logic          strobe;
  logic          send_req;
  logic          sent;
  logic          changed;
  logic [31:0]   elapsed;
  logic [31:0]   next_buttons;
  logic [jrs_pkg::MAX_AXES*AW-1:0] packed_axes;

  assign elapsed      = item_i.now_ms - last_time_q;
  assign next_buttons = (buttons_q & ~item_i.button_mask) |
                        (item_i.button_values & item_i.button_mask);

  always_comb begin
    enabled_d      = enabled_q;
    axis_d         = axis_q;
    buttons_d      = buttons_q;
    mounted_prev_d = mounted_prev_q;
    seq_d          = seq_q;
    pending_d      = pending_q;
    last_time_d    = last_time_q;
    period_d       = period_q;
    strobe         = 1'b0;
    send_req       = 1'b0;
    changed        = 1'b0;
    case (item_i.action)
      jrs_pkg::ACT_TICK: begin
        if (item_i.host_mounted != mounted_prev_q) begin
          mounted_prev_d = item_i.host_mounted;
          if (enabled_q) begin
            pending_d = 1'b1;
          end
        end
        if (enabled_q && (pending_d || elapsed >= {16'd0, period_q})) begin
          send_req = 1'b1;
        end
      end
      jrs_pkg::ACT_SET: begin
        if (enabled_q) begin
          for (int i = 0; i < AXES; i++) begin
            if (item_i.axis_en[i] && axis_q[i] != item_i.axes_packed[AW*i +: AW]) begin
              axis_d[i] = item_i.axes_packed[AW*i +: AW];
              changed   = 1'b1;
            end
          end
          if (next_buttons != buttons_q) begin
            buttons_d = next_buttons;
            changed   = 1'b1;
          end
          if (changed) begin
            strobe    = 1'b1;
            pending_d = 1'b1;
          end
        end
      end
      jrs_pkg::ACT_ENABLE: begin
        enabled_d = 1'b1;
        period_d  = (item_i.period_request_ms != 16'd0) ? item_i.period_request_ms
                                                        : default_period_q;
        pending_d = 1'b1;
        strobe    = 1'b1;
      end
      jrs_pkg::ACT_DISABLE: begin
        for (int i = 0; i < AXES; i++) begin
          axis_d[i] = '0;
        end
        buttons_d = '0;
        strobe    = 1'b1;
        if (enabled_q) begin
          pending_d = 1'b1;
          send_req  = 1'b1;
        end
        enabled_d = 1'b0;
      end
      jrs_pkg::ACT_RESET: begin
        enabled_d = 1'b0;
        for (int i = 0; i < AXES; i++) begin
          axis_d[i] = '0;
        end
        buttons_d = '0;
        period_d  = default_period_q;
        strobe    = 1'b1;
      end
      default: begin
      end
    endcase
    sent = send_req & item_i.send_ready;
    if (sent) begin
      seq_d       = seq_q + 8'd1;
      pending_d   = 1'b0;
      last_time_d = item_i.now_ms;
    end
  end

  always_comb begin
    packed_axes = '0;
    for (int i = 0; i < AXES; i++) begin
      packed_axes[AW*i +: AW] = axis_d[i];
    end
  end

  assign result_o.submit_strobe  = strobe;
  assign result_o.report_sent    = sent;
  assign result_o.axes_out       = packed_axes;
  assign result_o.buttons_out    = buttons_d;
  assign result_o.report_mounted = sent & item_i.host_mounted;
  assign result_o.report_seq     = sent ? seq_q : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_period_q <= jrs_pkg::RESET_PERIOD_MS;
    end else if (cfg_we_i) begin
      default_period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        axis_q[i] <= '0;
      end
      buttons_q      <= '0;
      mounted_prev_q <= 1'b0;
      seq_q          <= '0;
      pending_q      <= 1'b0;
      last_time_q    <= '0;
      period_q       <= jrs_pkg::RESET_PERIOD_MS;
    end else if (step_i) begin
      enabled_q      <= enabled_d;
      axis_q         <= axis_d;
      buttons_q      <= buttons_d;
      mounted_prev_q <= mounted_prev_d;
      seq_q          <= seq_d;
      pending_q      <= pending_d;
      last_time_q    <= last_time_d;
      period_q       <= period_d;
    end
  end

  `JRS_ASSERT_SEQ(a_seq_advance, clk_i, rst_ni,
    (step_i && sent) |=> (seq_q == $past(seq_q) + 8'd1))
  `JRS_ASSERT_SEQ(a_pending_clear, clk_i, rst_ni, (step_i && sent) |=> !pending_q)
  `JRS_ASSERT_COMB(a_quiet_report, clk_i, rst_ni,
    sent || (result_o.report_seq == 8'd0 && !result_o.report_mounted))
  `JRS_ASSERT_SEQ(a_hold_idle, clk_i, rst_ni,
    !step_i |=> ($stable(seq_q) && $stable(enabled_q) && $stable(pending_q)))

endmodule

// ===== rtl/jrs_out_stage.sv =====
// Result register stage toward the report stream.
module jrs_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  jrs_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               down_ready_i,
  output jrs_pkg::out_item_t item_o
);

  logic               valid_q;
  jrs_pkg::out_item_t item_q;

  assign ready_o = ~valid_q | down_ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the joystick report scheduler: directed table, then checked random requests.
module tb;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_REQS   = 390;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned AXES         = jrs_pkg::AXES_DEFAULT;
  localparam logic [2:0]  ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0]  ACT_UNDEF_HI = 3'd7;

  localparam jrs_pkg::out_item_t NO_RESULT  = '0;
  localparam jrs_pkg::out_item_t STROBE_RES = '{submit_strobe: 1'b1, default: '0};
  localparam jrs_pkg::out_item_t FIRST_SENT = '{report_sent: 1'b1, report_mounted: 1'b1,
                                                default: '0};

  typedef struct {
    jrs_pkg::in_item_t  rq;
    bit                 typed;
    jrs_pkg::out_item_t want;
  } dir_row_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [15:0]                    cfg_data_i    = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [jrs_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [2:0]                     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [jrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [15:0] dflt_period_q = jrs_pkg::RESET_PERIOD_MS;
  logic [15:0] period_q      = jrs_pkg::RESET_PERIOD_MS;
  logic        enabled_q     = 1'b0;
  logic        pending_q     = 1'b0;
  logic        mnt_prev_q    = 1'b0;
  logic [63:0] axes_q        = '0;
  logic [31:0] buttons_q     = '0;
  logic [7:0]  seq_q         = '0;
  logic [31:0] last_time_q   = '0;

  jrs_pkg::out_item_t report_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rx_hold      = 0;
  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;
  logic [31:0] host_ms      = '0;

  joystick_report_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial forever #CLK_HALF clk_i = ~clk_i;

  function automatic jrs_pkg::out_item_t schedule_report(jrs_pkg::in_item_t rq);
    jrs_pkg::out_item_t res;
    logic [31:0]        btn_next;
    logic               changed;
    logic               send;
    res     = '0;
    changed = 1'b0;
    send    = 1'b0;
    case (rq.action)
      jrs_pkg::ACT_TICK: begin
        if (rq.host_mounted != mnt_prev_q) begin
          mnt_prev_q = rq.host_mounted;
          if (enabled_q) pending_q = 1'b1;
        end
        send = enabled_q && (pending_q || (rq.now_ms - last_time_q) >= {16'd0, period_q});
      end
      jrs_pkg::ACT_SET: begin
        if (enabled_q) begin
          for (int i = 0; i < AXES; i++) begin
            if (rq.axis_en[i] && axes_q[16*i +: 16] != rq.axes_packed[16*i +: 16]) begin
              axes_q[16*i +: 16] = rq.axes_packed[16*i +: 16];
              changed = 1'b1;
            end
          end
          btn_next = (buttons_q & ~rq.button_mask) | (rq.button_values & rq.button_mask);
          if (btn_next != buttons_q) begin
            buttons_q = btn_next;
            changed   = 1'b1;
          end
          if (changed) begin
            res.submit_strobe = 1'b1;
            pending_q         = 1'b1;
          end
        end
      end
      jrs_pkg::ACT_ENABLE: begin
        enabled_q         = 1'b1;
        period_q          = (rq.period_request_ms != 16'd0) ? rq.period_request_ms
                                                            : dflt_period_q;
        pending_q         = 1'b1;
        res.submit_strobe = 1'b1;
      end
      jrs_pkg::ACT_DISABLE: begin
        axes_q            = '0;
        buttons_q         = '0;
        res.submit_strobe = 1'b1;
        if (enabled_q) begin
          pending_q = 1'b1;
          send      = 1'b1;
        end
        enabled_q = 1'b0;
      end
      jrs_pkg::ACT_RESET: begin
        enabled_q         = 1'b0;
        axes_q            = '0;
        buttons_q         = '0;
        period_q          = dflt_period_q;
        res.submit_strobe = 1'b1;
      end
      default: ;
    endcase
    if (send && rq.send_ready) begin
      res.report_sent    = 1'b1;
      res.report_seq     = seq_q;
      res.report_mounted = rq.host_mounted;
      seq_q              = seq_q + 8'd1;
      pending_q          = 1'b0;
      last_time_q        = rq.now_ms;
    end
    res.axes_out    = axes_q;
    res.buttons_out = buttons_q;
    return res;
  endfunction

  function automatic jrs_pkg::in_item_t mk_req(logic [2:0] act, logic [3:0] amask,
                                               logic [63:0] axes, logic [31:0] bmask,
                                               logic [31:0] bvals, logic [15:0] preq,
                                               logic mnt, logic rdy, logic [31:0] now);
    jrs_pkg::in_item_t rq;
    rq.action            = act;
    rq.axis_en           = amask;
    rq.axes_packed       = axes;
    rq.button_mask       = bmask;
    rq.button_values     = bvals;
    rq.period_request_ms = preq;
    rq.host_mounted      = mnt;
    rq.send_ready        = rdy;
    rq.now_ms            = now;
    return rq;
  endfunction

  function automatic jrs_pkg::in_item_t random_request();
    jrs_pkg::in_item_t rq;
    int unsigned       pick;
    pick                 = $urandom_range(0, 99);
    rq.axis_en           = 4'($urandom);
    rq.axes_packed       = {$urandom, $urandom};
    rq.button_mask       = $urandom;
    rq.button_values     = $urandom;
    case ($urandom_range(0, 3))
      0:       rq.period_request_ms = 16'($urandom);
      1:       rq.period_request_ms = 16'd0;
      default: rq.period_request_ms = 16'($urandom_range(1, 40));
    endcase
    rq.host_mounted = ($urandom_range(0, 9) == 0) ? !mnt_prev_q : mnt_prev_q;
    rq.send_ready   = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 49) == 0) begin
      host_ms = $urandom;
    end else begin
      host_ms = host_ms + $urandom_range(0, 30);
    end
    rq.now_ms = host_ms;
    if (pick < 43) begin
      rq.action = jrs_pkg::ACT_TICK;
    end else if (pick < 78) begin
      rq.action = jrs_pkg::ACT_SET;
      if ($urandom_range(0, 4) == 0) begin
        rq.axes_packed   = axes_q;
        rq.button_values = buttons_q;
      end
    end else if (pick < 88) begin
      rq.action = jrs_pkg::ACT_ENABLE;
    end else if (pick < 93) begin
      rq.action = jrs_pkg::ACT_DISABLE;
    end else if (pick < 96) begin
      rq.action = jrs_pkg::ACT_RESET;
    end else begin
      rq.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    end
    return rq;
  endfunction

  task automatic send_request(jrs_pkg::in_item_t rq, bit typed, jrs_pkg::out_item_t want);
    int unsigned        gap;
    jrs_pkg::out_item_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.action;
    s_axis_tdata  <= {2'b00, rq.now_ms, rq.send_ready, rq.host_mounted, rq.period_request_ms,
                      rq.button_values, rq.button_mask, rq.axes_packed, rq.axis_en};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = schedule_report(rq);
    report_q.push_back(typed ? want : pred);
  endtask

  task automatic write_default_period(logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    dflt_period_q = val;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on %s: expected %0h, actual %0h", what, want, got);
  endtask

  always @(posedge clk_i) begin : rx_side
    jrs_pkg::out_item_t seen;
    jrs_pkg::out_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.submit_strobe  = m_axis_tdata[0];
        seen.report_sent    = m_axis_tdata[1];
        seen.axes_out       = m_axis_tdata[65:2];
        seen.buttons_out    = m_axis_tdata[97:66];
        seen.report_mounted = m_axis_tdata[98];
        seen.report_seq     = m_axis_tdata[106:99];
        if (report_q.size() == 0) begin
          note_mismatch("unrequested result", '0, m_axis_tdata[63:0]);
        end else begin
          want = report_q.pop_front();
          if (seen.submit_strobe !== want.submit_strobe)
            note_mismatch("submit_strobe", want.submit_strobe, seen.submit_strobe);
          if (seen.report_sent !== want.report_sent)
            note_mismatch("report_sent", want.report_sent, seen.report_sent);
          if (seen.axes_out !== want.axes_out)
            note_mismatch("axes_out", want.axes_out, seen.axes_out);
          if (seen.buttons_out !== want.buttons_out)
            note_mismatch("buttons_out", want.buttons_out, seen.buttons_out);
          if (seen.report_mounted !== want.report_mounted)
            note_mismatch("report_mounted", want.report_mounted, seen.report_mounted);
          if (seen.report_seq !== want.report_seq)
            note_mismatch("report_seq", want.report_seq, seen.report_seq);
        end
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 15);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      m_axis_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    tab[$];
    logic [15:0] cfg_vals[5];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b1, 32'd0),
                    1'b1, NO_RESULT});
    tab.push_back('{mk_req(ACT_UNDEF_HI, 4'hF, '1, '1, '1, 16'hFFFF, 1'b1, 1'b1, '1),
                    1'b1, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_SET, 4'hF, '1, '1, '1, 16'hFFFF, 1'b1, 1'b1, '1),
                    1'b1, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_DISABLE, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b1, 32'd1),
                    1'b1, STROBE_RES});
    tab.push_back('{mk_req(jrs_pkg::ACT_ENABLE, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b1, 32'd2),
                    1'b1, STROBE_RES});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b0, 32'd10),
                    1'b1, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd20),
                    1'b1, FIRST_SENT});
    tab.push_back('{mk_req(jrs_pkg::ACT_SET, 4'hF, 64'h8000_7FFF_FFFF_0001, '1,
                           32'h8000_0001, 16'h0, 1'b1, 1'b1, 32'd21), 1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_SET, 4'hF, 64'h8000_7FFF_FFFF_0001, '1,
                           32'h8000_0001, 16'h0, 1'b1, 1'b1, 32'd22), 1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_SET, 4'h0, '1, '0, '1, 16'h0, 1'b1, 1'b1, 32'd23),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_SET, 4'h5, '1, 32'h0000_FFFF, '0, 16'h0, 1'b1, 1'b1,
                           32'd24), 1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd30),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd529),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd530),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, '1),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b0, 32'd5),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_DISABLE, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b1, 32'd6),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd7),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_ENABLE, 4'h0, '0, '0, '0, 16'hFFFF, 1'b1, 1'b1, 32'd8),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd9),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd65543),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_TICK, 4'h0, '0, '0, '0, 16'h0, 1'b1, 1'b1, 32'd65544),
                    1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_ENABLE, 4'h0, '0, '0, '0, 16'h1, 1'b1, 1'b1,
                           32'd65545), 1'b0, NO_RESULT});
    tab.push_back('{mk_req(jrs_pkg::ACT_RESET, 4'hF, '1, '1, '1, 16'hFFFF, 1'b1, 1'b1,
                           32'd65546), 1'b1, STROBE_RES});
    tab.push_back('{mk_req(ACT_UNDEF_LO, 4'h0, '0, '0, '0, 16'h0, 1'b0, 1'b0, 32'd0),
                    1'b1, NO_RESULT});
    foreach (tab[i]) send_request(tab[i].rq, tab[i].typed, tab[i].want);

    cfg_vals = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), jrs_pkg::RESET_PERIOD_MS};
    foreach (cfg_vals[p]) begin
      wait_drained();
      write_default_period(cfg_vals[p]);
      send_request(mk_req(jrs_pkg::ACT_RESET, 4'h0, '0, '0, '0, 16'h0, mnt_prev_q, 1'b1,
                          host_ms), 1'b0, NO_RESULT);
      send_request(mk_req(jrs_pkg::ACT_ENABLE, 4'h0, '0, '0, '0, 16'h0, mnt_prev_q, 1'b1,
                          host_ms), 1'b0, NO_RESULT);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 50 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        send_request(random_request(), 1'b0, NO_RESULT);
      end
    end

    wait_drained();
    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
